FILE: sv/ouoc_pkg.sv
// Shared types and constants for the OV/UV/OC trip and recovery block.
// Used by ouoc_regs, ouoc_eval and the top level; no dependencies.
package ouoc_pkg;

    // Hysteresis bands in native units (0.1 V, 0.01 A)
    localparam logic [16:0] OV_HYST = 17'd20;
    localparam logic [16:0] UV_HYST = 17'd20;
    localparam logic [16:0] OC_HYST = 17'd50;

    // Register reset values
    localparam logic [15:0] OV_LIM_RST = 16'd2500;
    localparam logic [15:0] UV_LIM_RST = 16'd1800;
    localparam logic [15:0] OC_LIM_RST = 16'd3000;
    localparam logic [15:0] LIVE_RST   = 16'd500;
    localparam logic [31:0] WIN_RST    = 32'd10000;

    typedef enum logic [1:0] {
        FK_NONE = 2'd0,
        FK_OV   = 2'd1,
        FK_UV   = 2'd2,
        FK_OC   = 2'd3
    } t_fault;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_OV_LIM = 3'd0,
        REG_UV_LIM = 3'd1,
        REG_OC_LIM = 3'd2,
        REG_LIVE   = 3'd3,
        REG_OV_WIN = 3'd4,
        REG_UV_WIN = 3'd5,
        REG_OC_WIN = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] ov_lim;
        logic [15:0] uv_lim;
        logic [15:0] oc_lim;
        logic [15:0] live;
        logic [31:0] ov_win;
        logic [31:0] uv_win;
        logic [31:0] oc_win;
    } t_cfg;

    typedef struct packed {
        logic        sample_valid;
        logic [15:0] line_voltage;
        logic [15:0] line_current;
        logic [31:0] now_ms;
        logic        emergency_off;
        logic [1:0]  active_meter;
    } t_sample;

    typedef struct packed {
        logic        last_valid;
        logic        trip;
        t_fault      fault;
        logic        running;
        logic [31:0] start_ms;
    } t_state;

    typedef struct packed {
        logic        trip_latched;
        t_fault      fault_kind;
        logic        window_open;
        logic        trip_event;
        logic        window_started;
        logic        window_cancelled;
        logic        clear_event;
        logic        restore_load;
        logic [1:0]  restore_meter;
    } t_result;

endpackage

FILE: sv/ouoc_regs.sv
// APB-style configuration registers for the trip and recovery block.
// Depends on ouoc_pkg (t_cfg, register index codes, reset values).
module ouoc_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output ouoc_pkg::t_cfg       o_cfg
);

    ouoc_pkg::t_cfg       r_cfg;
    ouoc_pkg::t_cfg       n_cfg;
    ouoc_pkg::t_reg_idx   idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = ouoc_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                ouoc_pkg::REG_OV_LIM: n_cfg.ov_lim = pwdata[15:0];
                ouoc_pkg::REG_UV_LIM: n_cfg.uv_lim = pwdata[15:0];
                ouoc_pkg::REG_OC_LIM: n_cfg.oc_lim = pwdata[15:0];
                ouoc_pkg::REG_LIVE:   n_cfg.live   = pwdata[15:0];
                ouoc_pkg::REG_OV_WIN: n_cfg.ov_win = pwdata;
                ouoc_pkg::REG_UV_WIN: n_cfg.uv_win = pwdata;
                ouoc_pkg::REG_OC_WIN: n_cfg.oc_win = pwdata;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ouoc_pkg::REG_OV_LIM: prdata = {16'd0, r_cfg.ov_lim};
            ouoc_pkg::REG_UV_LIM: prdata = {16'd0, r_cfg.uv_lim};
            ouoc_pkg::REG_OC_LIM: prdata = {16'd0, r_cfg.oc_lim};
            ouoc_pkg::REG_LIVE:   prdata = {16'd0, r_cfg.live};
            ouoc_pkg::REG_OV_WIN: prdata = r_cfg.ov_win;
            ouoc_pkg::REG_UV_WIN: prdata = r_cfg.uv_win;
            ouoc_pkg::REG_OC_WIN: prdata = r_cfg.oc_win;
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ov_lim <= ouoc_pkg::OV_LIM_RST;
            r_cfg.uv_lim <= ouoc_pkg::UV_LIM_RST;
            r_cfg.oc_lim <= ouoc_pkg::OC_LIM_RST;
            r_cfg.live   <= ouoc_pkg::LIVE_RST;
            r_cfg.ov_win <= ouoc_pkg::WIN_RST;
            r_cfg.uv_win <= ouoc_pkg::WIN_RST;
            r_cfg.oc_win <= ouoc_pkg::WIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: sv/ouoc_eval.sv
// Per-sample protection decision: fault detect, recovery band, window timer.
// Pure combinational; depends on ouoc_pkg for state, sample and result types.
module ouoc_eval (
    input  ouoc_pkg::t_state     i_state,
    input  ouoc_pkg::t_sample    i_sample,
    input  ouoc_pkg::t_cfg       i_cfg,
    output ouoc_pkg::t_state     o_state,
    output ouoc_pkg::t_result    o_result
);

    logic [16:0]      v17;
    logic [16:0]      i17;
    logic             is_ov;
    logic             is_uv;
    logic             is_oc;
    ouoc_pkg::t_fault det;
    logic             bad;
    logic [31:0]      start_eff;
    logic [31:0]      elapsed;
    logic [31:0]      win;

    assign v17 = {1'b0, i_sample.line_voltage};
    assign i17 = {1'b0, i_sample.line_current};

    // fault detect, priority OV > UV > OC
    assign is_ov = i_sample.line_voltage > i_cfg.ov_lim;
    assign is_uv = (i_sample.line_voltage > i_cfg.live) &&
                   (i_sample.line_voltage < i_cfg.uv_lim);
    assign is_oc = i_sample.line_current > i_cfg.oc_lim;

    always_comb begin
        if (is_ov)      det = ouoc_pkg::FK_OV;
        else if (is_uv) det = ouoc_pkg::FK_UV;
        else if (is_oc) det = ouoc_pkg::FK_OC;
        else            det = ouoc_pkg::FK_NONE;
    end

    // still inside the hysteresis band; limit - hyst < 0 never recovers
    always_comb begin
        case (i_state.fault)
            ouoc_pkg::FK_OV: bad = (v17 + ouoc_pkg::OV_HYST) >= {1'b0, i_cfg.ov_lim};
            ouoc_pkg::FK_UV: bad = (i_sample.line_voltage > i_cfg.live) &&
                                   (v17 <= ({1'b0, i_cfg.uv_lim} + ouoc_pkg::UV_HYST));
            ouoc_pkg::FK_OC: bad = (i17 + ouoc_pkg::OC_HYST) >= {1'b0, i_cfg.oc_lim};
            default:         bad = 1'b0;
        endcase
    end

    always_comb begin
        case (i_state.fault)
            ouoc_pkg::FK_UV: win = i_cfg.uv_win;
            ouoc_pkg::FK_OC: win = i_cfg.oc_win;
            default:         win = i_cfg.ov_win;
        endcase
    end

    // reconnect restarts a running window
    assign start_eff = (!i_state.last_valid && i_state.running) ? i_sample.now_ms
                                                                : i_state.start_ms;
    assign elapsed   = i_sample.now_ms - start_eff;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (!i_sample.sample_valid) begin
            o_state.last_valid = 1'b0;
        end else begin
            o_state.last_valid = 1'b1;
            o_state.start_ms   = start_eff;
            if (!i_state.trip) begin
                if (det != ouoc_pkg::FK_NONE) begin
                    o_state.trip        = 1'b1;
                    o_state.fault       = det;
                    o_state.running     = 1'b0;
                    o_result.trip_event = 1'b1;
                end
            end else if (i_state.fault != ouoc_pkg::FK_NONE) begin
                if (bad) begin
                    if (i_state.running) begin
                        o_state.running           = 1'b0;
                        o_result.window_cancelled = 1'b1;
                    end
                end else if (!i_state.running) begin
                    o_state.running         = 1'b1;
                    o_state.start_ms        = i_sample.now_ms;
                    o_result.window_started = 1'b1;
                end else if (elapsed >= win) begin
                    o_state.trip          = 1'b0;
                    o_state.running       = 1'b0;
                    o_state.fault         = ouoc_pkg::FK_NONE;
                    o_result.clear_event  = 1'b1;
                    o_result.restore_load = !i_sample.emergency_off;
                    o_result.restore_meter = i_sample.emergency_off ? 2'd0
                                                                    : i_sample.active_meter;
                end
            end
        end
        o_result.trip_latched = o_state.trip;
        o_result.fault_kind   = o_state.fault;
        o_result.window_open  = o_state.running;
    end

endmodule

FILE: sv/ov_uv_oc_trip_and_recovery.sv
// Top level of the over-voltage / under-voltage / over-current trip relay.
// Depends on ouoc_pkg, ouoc_regs (APB registers) and ouoc_eval (decision).
//
// Usage:
//  - Input stream (s_*): one meter sample per word. s_tuser carries the
//    meter's sample_valid flag; s_tdata carries voltage, current, the ms
//    timestamp, the emergency veto and the active meter index.
//  - Output stream (m_*): one status word per sample: latched trip, fault
//    kind, window state, event strobes and the relay restore command.
//  - APB port: seven limit/window registers at byte offsets 0x00..0x18.
//    Write only while no sample is in flight.
//  - Path: a word taken on the s_* side is captured in the input register,
//    then passes through the decision logic into the result register, which
//    drives m_tvalid. Throughput is one word per cycle while m_tready is high;
//    the decision path between the two registers is combinational.
//  - Stall: while m_tready is low the result register holds and the input
//    register can still take one word; s_tready drops only when both are
//    full, so no word is lost or duplicated.
//  - Reset (synchronous, active low): no trip latched, no window running,
//    meter considered offline, registers back to their defaults.
module ov_uv_oc_trip_and_recovery (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] line_voltage, [31:16] line_current, [63:32] now_ms,
    // [64] emergency_off, [66:65] active_meter, [71:67] zero
    input  logic [71:0]  s_tdata,
    // [0] sample_valid
    input  logic         s_tuser,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] trip_latched, [2:1] fault_kind, [3] window_open, [4] trip_event,
    // [5] window_started, [6] window_cancelled, [7] clear_event,
    // [8] restore_load, [10:9] restore_meter, [15:11] zero
    output logic [15:0]  m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ouoc_pkg::t_cfg      cfg;

    // input register
    logic                r_in_vld;
    logic                n_in_vld;
    ouoc_pkg::t_sample   r_in;

    // protection state
    ouoc_pkg::t_state    r_state;
    ouoc_pkg::t_state    n_state;

    // result register
    logic                r_out_vld;
    logic                n_out_vld;
    ouoc_pkg::t_result   r_out;
    ouoc_pkg::t_result   n_out;

    logic                in_acc;
    logic                adv;

    ouoc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ouoc_eval u_eval (
        .i_state  (r_state),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // word moves from input reg to result reg when result slot frees up
    assign adv      = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_in_vld || adv;
    assign in_acc   = s_tvalid && s_tready;

    assign n_in_vld  = in_acc || (r_in_vld && !adv);
    assign n_out_vld = adv || (r_out_vld && !m_tready);

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {5'd0, r_out.restore_meter, r_out.restore_load,
                       r_out.clear_event, r_out.window_cancelled,
                       r_out.window_started, r_out.trip_event,
                       r_out.window_open, r_out.fault_kind, r_out.trip_latched};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // sample payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.sample_valid  <= s_tuser;
            r_in.line_voltage  <= s_tdata[15:0];
            r_in.line_current  <= s_tdata[31:16];
            r_in.now_ms        <= s_tdata[63:32];
            r_in.emergency_off <= s_tdata[64];
            r_in.active_meter  <= s_tdata[66:65];
        end
    end

    // state and result commit together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_valid <= 1'b0;
            r_state.trip       <= 1'b0;
            r_state.fault      <= ouoc_pkg::FK_NONE;
            r_state.running    <= 1'b0;
            r_state.start_ms   <= 32'd0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    // no fault kind or window without a latched trip
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.trip |-> (r_state.fault == ouoc_pkg::FK_NONE && !r_state.running))
        else $error("fault or window held without trip");

    // state moves only when a word is committed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_state))
        else $error("protection state changed without a committed word");

    // a clear leaves no trip latched in the same word
    a_clear_untrip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.clear_event) |-> (!r_out.trip_latched && !r_out.window_open))
        else $error("clear event with trip still latched");

    // restore only as part of a clear
    a_restore_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.restore_load || r_out.restore_meter != 2'd0))
            |-> r_out.clear_event)
        else $error("restore command without clear");

endmodule
